// File: hw/rtl/mcc_pkg.sv
`default_nettype none

package mcc_pkg;

    // denomination limits and table geometry
    localparam int MAX_COINS  = 6;
    localparam int MAX_AMOUNT = 4095;
    localparam int COIN_REGS  = 6;
    localparam int VAL_W      = 12;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int SLOT_W     = $clog2(COIN_REGS);
    localparam int ENTRY_W    = VAL_W + 1;
    localparam int DEPTH      = MAX_AMOUNT + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CMP_W      = (ADDR_W > VAL_W) ? ADDR_W : VAL_W;

    // table entry with only the unreachable flag set
    localparam logic [ENTRY_W-1:0] UNREACH = {1'b1, {VAL_W{1'b0}}};

    typedef logic [VAL_W-1:0] t_val;
    typedef t_val [COIN_REGS-1:0] t_coin_arr;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT  = 3'd0,
        CFG_COIN_0 = 3'd1,
        CFG_COIN_1 = 3'd2,
        CFG_COIN_2 = 3'd3,
        CFG_COIN_3 = 3'd4,
        CFG_COIN_4 = 3'd5,
        CFG_COIN_5 = 3'd6
    } t_cfg_idx;

    // top level to engine
    typedef struct packed {
        logic start;
        t_val amount;
        logic ack;
    } t_eng_req;

    // engine to top level
    typedef struct packed {
        logic idle;
        logic done;
        t_val min_coins;
        logic no_solution;
    } t_eng_res;

endpackage

`default_nettype wire

// File: hw/rtl/mcc_ram.sv
`default_nettype none

module mcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/mcc_engine.sv
`default_nettype none

module mcc_engine (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire mcc_pkg::t_eng_req                       i_req,
    input  wire mcc_pkg::t_coin_arr                      i_coins,
    input  wire logic [mcc_pkg::CNT_W-1:0]               i_coin_count,
    output mcc_pkg::t_eng_res                            o_res
);

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_INIT = 4'b0010,
        E_RUN  = 4'b0100,
        E_DONE = 4'b1000
    } t_eng_state;

    t_eng_state                          r_state, n_state;
    logic [mcc_pkg::ADDR_W-1:0]          r_a, n_a;
    logic [mcc_pkg::ADDR_W-1:0]          r_target, n_target;
    logic [mcc_pkg::SLOT_W-1:0]          r_slot, n_slot;
    logic [mcc_pkg::ENTRY_W-1:0]         r_best, n_best;
    logic                                r_wr, n_wr;
    logic                                r_cand_v, n_cand_v;
    mcc_pkg::t_val                       r_res_min, n_res_min;
    logic                                r_res_nosol, n_res_nosol;

    logic [mcc_pkg::SLOT_W-1:0]          last_slot;
    mcc_pkg::t_val                       coin_c;
    logic                                issue_ok;
    logic [mcc_pkg::CMP_W-1:0]           diff;
    logic [mcc_pkg::ADDR_W-1:0]          raddr;
    logic [mcc_pkg::ENTRY_W-1:0]         rdata;
    logic [mcc_pkg::ENTRY_W-1:0]         cand;
    logic [mcc_pkg::ENTRY_W-1:0]         best_cmp;
    logic                                ram_we;
    logic [mcc_pkg::ADDR_W-1:0]          waddr;
    logic [mcc_pkg::ENTRY_W-1:0]         wdata;

    // best count table, rebuilt for every nonzero query
    mcc_ram #(
        .WIDTH (mcc_pkg::ENTRY_W),
        .DEPTH (mcc_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // denomination slot issue: read entry a - c when the coin fits
    always_comb begin
        last_slot = (i_coin_count == '0) ? '0 : mcc_pkg::SLOT_W'(i_coin_count - 1'b1);
        coin_c    = (32'(r_slot) < mcc_pkg::COIN_REGS) ? i_coins[r_slot] : '0;
        issue_ok  = (mcc_pkg::CNT_W'(r_slot) < i_coin_count) && (coin_c != '0) &&
                    (mcc_pkg::CMP_W'(coin_c) <= mcc_pkg::CMP_W'(r_a));
        diff      = mcc_pkg::CMP_W'(r_a) - mcc_pkg::CMP_W'(coin_c);
        raddr     = diff[mcc_pkg::ADDR_W-1:0];
    end

    // shared compare unit: candidate from last read against running best
    always_comb begin
        cand     = {1'b0, rdata[mcc_pkg::VAL_W-1:0]} + mcc_pkg::ENTRY_W'(1);
        best_cmp = (r_cand_v && !rdata[mcc_pkg::VAL_W] && (cand < r_best)) ? cand : r_best;
    end

    // table write: entry zero at start, then one entry per amount
    always_comb begin
        ram_we = (r_state == E_INIT) || ((r_state == E_RUN) && r_wr);
        waddr  = (r_state == E_INIT) ? '0 : r_a;
        wdata  = (r_state == E_INIT) ? '0 : best_cmp;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_target    = r_target;
        n_slot      = r_slot;
        n_best      = r_best;
        n_wr        = r_wr;
        n_cand_v    = r_cand_v;
        n_res_min   = r_res_min;
        n_res_nosol = r_res_nosol;
        case (r_state)
            E_IDLE: begin
                if (i_req.start) begin
                    if (32'(i_req.amount) > mcc_pkg::MAX_AMOUNT) begin
                        n_res_min   = '0;
                        n_res_nosol = 1'b1;
                        n_state     = E_DONE;
                    end else if (i_req.amount == '0) begin
                        n_res_min   = '0;
                        n_res_nosol = 1'b0;
                        n_state     = E_DONE;
                    end else begin
                        n_target = mcc_pkg::ADDR_W'(i_req.amount);
                        n_state  = E_INIT;
                    end
                end
            end
            E_INIT: begin
                n_a      = mcc_pkg::ADDR_W'(1);
                n_slot   = '0;
                n_best   = mcc_pkg::UNREACH;
                n_wr     = 1'b0;
                n_cand_v = 1'b0;
                n_state  = E_RUN;
            end
            E_RUN: begin
                if (!r_wr) begin
                    n_cand_v = issue_ok;
                    n_best   = best_cmp;
                    if (r_slot == last_slot) begin
                        n_wr = 1'b1;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end else begin
                    n_cand_v = 1'b0;
                    n_wr     = 1'b0;
                    n_slot   = '0;
                    n_best   = mcc_pkg::UNREACH;
                    if (r_a == r_target) begin
                        n_res_nosol = best_cmp[mcc_pkg::VAL_W];
                        n_res_min   = best_cmp[mcc_pkg::VAL_W] ? '0 :
                                      best_cmp[mcc_pkg::VAL_W-1:0];
                        n_state     = E_DONE;
                    end else begin
                        n_a = r_a + 1'b1;
                    end
                end
            end
            E_DONE: begin
                if (i_req.ack) begin
                    n_state = E_IDLE;
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_wr     <= 1'b0;
            r_cand_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr     <= n_wr;
            r_cand_v <= n_cand_v;
        end
        r_a         <= n_a;
        r_target    <= n_target;
        r_slot      <= n_slot;
        r_best      <= n_best;
        r_res_min   <= n_res_min;
        r_res_nosol <= n_res_nosol;
    end

    // status back to the top level
    always_comb begin
        o_res.idle        = (r_state == E_IDLE);
        o_res.done        = (r_state == E_DONE);
        o_res.min_coins   = r_res_min;
        o_res.no_solution = r_res_nosol;
    end

endmodule

`default_nettype wire

// File: hw/rtl/min_coin_change_core.sv
`default_nettype none

// Fewest-coins change maker. Each accepted amount rebuilds a table of best
// counts over the amounts 1 to the target, one amount after another, trying
// every denomination in use through one shared read-compare slot against a
// table memory with one write port and one registered read port. Each amount
// takes at least one slot, even with no denomination in use; zero amounts
// answer without building the table. Input is stalled while a query runs; a
// finished result waits in the output register and does not hold up the
// next query. Configuration writes must only happen while the block is idle.
module min_coin_change_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [mcc_pkg::VAL_W-1:0]          i_amount,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic      [mcc_pkg::VAL_W-1:0]          o_min_coins,
    output logic                                    o_no_solution,
    input  wire logic                               i_cfg_we,
    input  wire logic [mcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mcc_pkg::VAL_W-1:0]          i_cfg_data
);

    logic [mcc_pkg::CNT_W-1:0]      r_coin_count;
    mcc_pkg::t_coin_arr             r_coins;
    logic [mcc_pkg::CNT_W-1:0]      coin_count_sat;
    logic                           r_out_valid, n_out_valid;
    mcc_pkg::t_val                  r_min_coins, n_min_coins;
    logic                           r_no_sol, n_no_sol;
    mcc_pkg::t_eng_req              eng_req;
    mcc_pkg::t_eng_res              eng_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin_count <= mcc_pkg::CNT_W'(1);
            for (int i = 0; i < mcc_pkg::COIN_REGS; i++) begin
                r_coins[i] <= mcc_pkg::VAL_W'(1);
            end
        end else if (i_cfg_we) begin
            case (mcc_pkg::t_cfg_idx'(i_cfg_index))
                mcc_pkg::CFG_COUNT:  r_coin_count <= i_cfg_data[mcc_pkg::CNT_W-1:0];
                mcc_pkg::CFG_COIN_0: r_coins[0]   <= i_cfg_data;
                mcc_pkg::CFG_COIN_1: r_coins[1]   <= i_cfg_data;
                mcc_pkg::CFG_COIN_2: r_coins[2]   <= i_cfg_data;
                mcc_pkg::CFG_COIN_3: r_coins[3]   <= i_cfg_data;
                mcc_pkg::CFG_COIN_4: r_coins[4]   <= i_cfg_data;
                mcc_pkg::CFG_COIN_5: r_coins[5]   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // denomination count saturates at the supported maximum
    always_comb begin
        coin_count_sat = (32'(r_coin_count) > mcc_pkg::MAX_COINS) ?
                         mcc_pkg::CNT_W'(mcc_pkg::MAX_COINS) : r_coin_count;
    end

    // input transfer starts the engine; result moves to the output register
    always_comb begin
        o_in_stall     = !eng_res.idle;
        eng_req.start  = i_in_valid && eng_res.idle;
        eng_req.amount = i_amount;
        eng_req.ack    = eng_res.done && (!r_out_valid || !i_out_stall);
    end

    mcc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (eng_req),
        .i_coins      (r_coins),
        .i_coin_count (coin_count_sat),
        .o_res        (eng_res)
    );

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_min_coins = r_min_coins;
        n_no_sol    = r_no_sol;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (eng_req.ack) begin
            n_out_valid = 1'b1;
            n_min_coins = eng_res.min_coins;
            n_no_sol    = eng_res.no_solution;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_min_coins <= n_min_coins;
        r_no_sol    <= n_no_sol;
    end

    assign o_out_valid   = r_out_valid;
    assign o_min_coins   = r_min_coins;
    assign o_no_solution = r_no_sol;

endmodule

`default_nettype wire

// File: tb/sv/min_coin_change_core_tb.sv
`timescale 1ns / 100ps

import mcc_pkg::*;

// expected-answer store: keeps its own copy of the coin setup and works out
// the fewest-coins answer for every amount the block takes
class change_scoreboard;

    localparam int unsigned NO_PATH = 32'h1000;

    typedef struct {
        t_val amount;
        t_val min_coins;
        logic no_solution;
    } t_change_answer;

    logic [CNT_W-1:0]   coin_count;
    t_val               coin_val [COIN_REGS];
    logic [VAL_W:0]     best_tbl [MAX_AMOUNT+1];
    t_change_answer     answers [$];
    int                 n_checked;
    int                 n_errors;
    int                 n_nosol;
    int                 n_big;

    function new();
        coin_count = 1;
        foreach (coin_val[k]) coin_val[k] = 1;
        n_checked = 0;
        n_errors  = 0;
        n_nosol   = 0;
        n_big     = 0;
    endfunction

    // mirror of one register write
    function void set_reg(t_cfg_idx idx, t_val data);
        if (idx == CFG_COUNT) begin
            coin_count = data[CNT_W-1:0];
        end else begin
            coin_val[int'(idx) - int'(CFG_COIN_0)] = data;
        end
    endfunction

    // bottom-up best counts over 0..amount for one accepted amount
    function void note_amount(t_val amt);
        int unsigned    n_use;
        int unsigned    best;
        int unsigned    prev;
        int unsigned    c;
        t_change_answer ans;
        n_use = (coin_count > MAX_COINS) ? MAX_COINS : coin_count;
        best_tbl[0] = '0;
        for (int a = 1; a <= int'(amt); a++) begin
            best = NO_PATH;
            for (int k = 0; k < int'(n_use); k++) begin
                c = coin_val[k];
                if (c != 0 && c <= a) begin
                    prev = best_tbl[a - c];
                    if (prev < NO_PATH && prev + 1 < best) best = prev + 1;
                end
            end
            best_tbl[a] = best[VAL_W:0];
        end
        ans.amount      = amt;
        ans.no_solution = best_tbl[amt][VAL_W];
        ans.min_coins   = ans.no_solution ? '0 : best_tbl[amt][VAL_W-1:0];
        if (ans.no_solution) n_nosol++;
        if (amt[VAL_W-1]) n_big++;
        answers = {answers, ans};
    endfunction

    // compare one result transfer with the oldest answer
    function void check_result(t_val got_coins, logic got_nosol);
        t_change_answer want;
        if (answers.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result: expected none, got min_coins %0d no_solution %0b",
                     $time, got_coins, got_nosol);
            return;
        end
        want = answers.pop_front();
        n_checked++;
        if (got_coins !== want.min_coins) begin
            n_errors++;
            $display("%0t: amount %0d min_coins: expected %0d, got %0d",
                     $time, want.amount, want.min_coins, got_coins);
        end
        if (got_nosol !== want.no_solution) begin
            n_errors++;
            $display("%0t: amount %0d no_solution: expected %0b, got %0b",
                     $time, want.amount, want.no_solution, got_nosol);
        end
    endfunction

endclass

module min_coin_change_core_tb;

    localparam int CYCLE_LIMIT = 5_000_000;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    t_val                   i_amount    = '0;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    t_val                   i_cfg_data  = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_val                   o_min_coins;
    logic                   o_no_solution;

    change_scoreboard       sb = new();
    int unsigned            src_idle_pct  = 0;
    int unsigned            snk_stall_pct = 0;
    int                     hold_req      = 0;
    int                     hold_left     = 0;
    int                     n_sent        = 0;
    int                     n_setups      = 0;
    int                     cycle_cnt     = 0;

    min_coin_change_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_amount      (i_amount),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_min_coins   (o_min_coins),
        .o_no_solution (o_no_solution),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output stall: long hold-off on request, otherwise random
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
        end
    end

    // watch both channels for transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_amount(i_amount);
            if (o_out_valid && !i_out_stall) sb.check_result(o_min_coins, o_no_solution);
        end
    end

    // offer one amount, with random idle cycles ahead of it
    task automatic send_amount(input t_val amt);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_amount   <= amt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
    endtask

    // drop valid and wait until every answer has come back
    task automatic close_burst();
        i_in_valid <= 1'b0;
        while (sb.n_checked < n_sent) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_val data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // write every register; block must be idle
    task automatic load_setup(input logic [CNT_W-1:0] count,
                              input t_val c0, input t_val c1, input t_val c2,
                              input t_val c3, input t_val c4, input t_val c5);
        write_reg(CFG_COUNT, t_val'(count));
        write_reg(CFG_COIN_0, c0);
        write_reg(CFG_COIN_1, c1);
        write_reg(CFG_COIN_2, c2);
        write_reg(CFG_COIN_3, c3);
        write_reg(CFG_COIN_4, c4);
        write_reg(CFG_COIN_5, c5);
        i_cfg_we <= 1'b0;
        n_setups++;
    endtask

    // mostly small coins, now and then zero or wide values
    function automatic t_val rand_coin();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return t_val'($urandom_range(0, 4095));
            2, 3:    return t_val'($urandom_range(41, 300));
            default: return t_val'($urandom_range(1, 40));
        endcase
    endfunction

    // count of zero, saturating count, or a normal one
    function automatic logic [CNT_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CNT_W'($urandom_range(1, MAX_COINS));
        endcase
    endfunction

    // small amounts keep queries short; a few span the full range
    function automatic t_val rand_amount();
        if ($urandom_range(0, 24) == 0) return t_val'($urandom_range(0, 4095));
        return t_val'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                input int n_items);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            // new coin setup every few queries, once the block is idle
            if (k % 8 == 0) begin
                close_burst();
                load_setup(rand_count(), rand_coin(), rand_coin(), rand_coin(),
                           rand_coin(), rand_coin(), rand_coin());
            end
            send_amount(rand_amount());
        end
        close_burst();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setup: one coin of value one
        send_amount('0);
        send_amount(12'd3);
        close_burst();

        // greedy would pick 4+1+1 here, best is 3+3
        load_setup(3'd3, 12'd1, 12'd3, 12'd4, 12'd0, 12'd0, 12'd0);
        send_amount(12'd6);
        send_amount(12'd1);
        send_amount(12'd0);
        close_burst();

        // only even sums reachable
        load_setup(3'd2, 12'd4, 12'd6, 12'd1, 12'd1, 12'd1, 12'd1);
        send_amount(12'd3);
        send_amount(12'd9);
        send_amount(12'd10);
        close_burst();

        // no denominations in use
        load_setup(3'd0, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
        send_amount(12'd5);
        send_amount(12'd0);
        close_burst();

        // count saturates, zero-valued coin ignored, largest coin and amount
        load_setup(3'd7, 12'd0, 12'd4095, 12'd7, 12'd11, 12'd2, 12'd13);
        send_amount(12'd4095);
        send_amount(12'd1);
        send_amount(12'd2048);
        close_burst();

        // largest supported count
        load_setup(3'd6, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
        send_amount(12'd4095);
        close_burst();

        // random traffic under each idling pattern
        random_phase(0, 0, 20);
        random_phase(60, 0, 20);
        random_phase(0, 60, 20);
        random_phase(38, 38, 20);

        // long output hold-off while amounts keep coming, so input backs up
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        load_setup(3'd2, 12'd1, 12'd2, 12'd5, 12'd5, 12'd5, 12'd5);
        hold_req = 1500;
        for (int k = 0; k < 12; k++) send_amount(t_val'($urandom_range(0, 30)));
        close_burst();

        repeat (40) @(posedge i_clk);
        if (sb.answers.size() != 0) begin
            sb.n_errors++;
            $display("%0t: %0d answers never arrived, oldest expected min_coins %0d no_solution %0b",
                     $time, sb.answers.size(), sb.answers[0].min_coins,
                     sb.answers[0].no_solution);
        end
        $display("checked %0d queries across %0d coin setups: %0d unreachable, %0d of 2048 or more",
                 sb.n_checked, n_setups, sb.n_nosol, sb.n_big);
        $display("field mismatches and stray results: %0d", sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
